// ===== hw/rtl/tccp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the text console command parser.
// No dependencies; every module imports this package, the two interfaces do not.
package tccp_pkg;

    // Character codes
    localparam logic [7:0] CHR_NUL  = 8'h00;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_ESC  = 8'h1B;
    localparam logic [7:0] CHR_F    = 8'h46;
    localparam logic [7:0] CHR_B    = 8'h42;
    localparam logic [7:0] CHR_ZERO = 8'h30;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Escape sequence positions
    localparam logic [3:0] ESC_IDLE     = 4'd0;
    localparam logic [3:0] ESC_SELECT   = 4'd1;
    localparam logic [3:0] ESC_DIGIT_R  = 4'd2;
    localparam logic [3:0] ESC_DIGIT_G  = 4'd5;
    localparam logic [3:0] ESC_DIGIT_B  = 4'd8;
    localparam logic [3:0] ESC_LAST     = 4'd10;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_TEXT_SCALE   = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH = 2'd1;
    localparam logic [1:0] REG_DEFAULT_FG   = 2'd2;
    localparam logic [1:0] REG_DEFAULT_BG   = 2'd3;

    localparam logic [3:0]  RST_TEXT_SCALE   = 4'd1;
    localparam logic [15:0] RST_SCREEN_WIDTH = 16'd640;
    localparam logic [31:0] RST_DEFAULT_FG   = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_DEFAULT_BG   = 32'hFF00_0000;

    // Command queue between front and back end
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_LF,
        CMD_CR,
        CMD_GLYPH
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [7:0]  code;
        logic [31:0] ink;
        logic [31:0] paper;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  text_scale;
        logic [15:0] screen_width;
        logic [31:0] default_fg;
        logic [31:0] default_bg;
    } cfg_t;

    typedef struct packed {
        logic fg;
        logic bg;
    } cfg_load_t;

endpackage

// ===== hw/rtl/tccp_in_if.sv =====
`timescale 1ns / 1ps
// Byte stream channel into the text console command parser.
// Standalone interface; no package needed.
interface tccp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

// ===== hw/rtl/tccp_out_if.sv =====
`timescale 1ns / 1ps
// Glyph draw request channel out of the text console command parser.
// Standalone interface; no package needed.
interface tccp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_code;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [31:0] ink_color;
    logic [31:0] paper_color;

    modport source (output valid, output glyph_code, output draw_x, output draw_y,
                    output ink_color, output paper_color, input ready);
    modport sink   (input valid, input glyph_code, input draw_x, input draw_y,
                    input ink_color, input paper_color, output ready);
endinterface

// ===== hw/rtl/tccp_regs.sv =====
`timescale 1ns / 1ps
// APB-style configuration registers of the text console command parser.
// Depends on tccp_pkg.
module tccp_regs
    import tccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg,
    output cfg_load_t          cfg_load
);

    logic [3:0]  text_scale_reg;
    logic [15:0] screen_width_reg;
    logic [31:0] default_fg_reg;
    logic [31:0] default_bg_reg;
    cfg_load_t   load_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_scale_reg   <= RST_TEXT_SCALE;
            screen_width_reg <= RST_SCREEN_WIDTH;
            default_fg_reg   <= RST_DEFAULT_FG;
            default_bg_reg   <= RST_DEFAULT_BG;
            load_reg         <= '0;
        end
        else
        begin
            load_reg.fg <= wr_en && (reg_idx == REG_DEFAULT_FG);
            load_reg.bg <= wr_en && (reg_idx == REG_DEFAULT_BG);
            if (wr_en)
            begin
                unique case (reg_idx)
                    REG_TEXT_SCALE:   text_scale_reg   <= pwdata[3:0];
                    REG_SCREEN_WIDTH: screen_width_reg <= pwdata[15:0];
                    REG_DEFAULT_FG:   default_fg_reg   <= pwdata;
                    REG_DEFAULT_BG:   default_bg_reg   <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TEXT_SCALE:   prdata = {28'd0, text_scale_reg};
            REG_SCREEN_WIDTH: prdata = {16'd0, screen_width_reg};
            REG_DEFAULT_FG:   prdata = default_fg_reg;
            REG_DEFAULT_BG:   prdata = default_bg_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.text_scale   = text_scale_reg;
    assign cfg.screen_width = screen_width_reg;
    assign cfg.default_fg   = default_fg_reg;
    assign cfg.default_bg   = default_bg_reg;
    assign cfg_load         = load_reg;

endmodule

// ===== hw/rtl/tccp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts bytes, runs the escape parser and the current colors,
// and turns printable bytes and cursor controls into queued commands. Uses tccp_pkg.
module tccp_front
    import tccp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tccp_in_if.sink      in_ch,
    input  cfg_t         cfg,
    input  cfg_load_t    cfg_load,
    input  logic         q_full,
    output logic         push,
    output cmd_t         push_cmd
);

    logic [3:0]  esc_pos_reg, esc_pos_next;
    logic [7:0]  esc_sel_reg, esc_sel_next;
    logic [23:0] acc_reg, acc_next;
    logic [31:0] ink_reg, ink_next;
    logic [31:0] paper_reg, paper_next;

    logic        accept;
    logic [7:0]  c;
    logic [23:0] acc_shift;
    logic [7:0]  low;
    logic [7:0]  low_new;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign c           = in_ch.text_byte;

    // Open a new color byte at the first digit of each triple
    assign acc_shift = (esc_pos_reg == ESC_DIGIT_R || esc_pos_reg == ESC_DIGIT_G ||
                        esc_pos_reg == ESC_DIGIT_B) ? {acc_reg[15:0], 8'h00} : acc_reg;
    assign low       = acc_shift[7:0];
    assign low_new   = {low[4:0], 3'b000} + {low[6:0], 1'b0} + (c - CHR_ZERO);

    always_comb
    begin
        esc_pos_next   = esc_pos_reg;
        esc_sel_next   = esc_sel_reg;
        acc_next       = acc_reg;
        ink_next       = ink_reg;
        paper_next     = paper_reg;
        push           = 1'b0;
        push_cmd.op    = CMD_GLYPH;
        push_cmd.code  = c;
        // Forward a default color written just before, ahead of the color register
        push_cmd.ink   = cfg_load.fg ? cfg.default_fg : ink_reg;
        push_cmd.paper = cfg_load.bg ? cfg.default_bg : paper_reg;

        if (cfg_load.fg)
        begin
            ink_next = cfg.default_fg;
        end
        if (cfg_load.bg)
        begin
            paper_next = cfg.default_bg;
        end

        if (accept)
        begin
            if (c != CHR_NUL)
            begin
                if (esc_pos_reg == ESC_SELECT)
                begin
                    esc_sel_next = c;
                    acc_next     = '0;
                    esc_pos_next = ESC_DIGIT_R;
                end
                else if (esc_pos_reg >= ESC_DIGIT_R && esc_pos_reg <= ESC_LAST)
                begin
                    acc_next     = {acc_shift[23:8], low_new};
                    esc_pos_next = esc_pos_reg + 4'd1;
                    if (esc_pos_reg == ESC_LAST)
                    begin
                        if (esc_sel_reg == CHR_F)
                        begin
                            ink_next = {ALPHA_OPAQUE, acc_shift[23:8], low_new};
                        end
                        else if (esc_sel_reg == CHR_B)
                        begin
                            paper_next = {ALPHA_OPAQUE, acc_shift[23:8], low_new};
                        end
                        esc_pos_next = ESC_IDLE;
                    end
                end
                else if (esc_pos_reg != ESC_IDLE)
                begin
                    esc_pos_next = ESC_IDLE;
                end
                else
                begin
                    case (c)
                        CHR_LF:
                        begin
                            push        = 1'b1;
                            push_cmd.op = CMD_LF;
                        end
                        CHR_CR:
                        begin
                            push        = 1'b1;
                            push_cmd.op = CMD_CR;
                        end
                        CHR_ESC:
                        begin
                            esc_pos_next = ESC_SELECT;
                        end
                        default:
                        begin
                            push        = 1'b1;
                            push_cmd.op = CMD_GLYPH;
                        end
                    endcase
                end
            end

            // End of string: revert colors, drop any pending escape
            if (c == CHR_NUL || in_ch.is_last)
            begin
                ink_next     = cfg.default_fg;
                paper_next   = cfg.default_bg;
                esc_pos_next = ESC_IDLE;
                esc_sel_next = '0;
                acc_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_pos_reg <= ESC_IDLE;
            esc_sel_reg <= '0;
            acc_reg     <= '0;
            ink_reg     <= RST_DEFAULT_FG;
            paper_reg   <= RST_DEFAULT_BG;
        end
        else
        begin
            esc_pos_reg <= esc_pos_next;
            esc_sel_reg <= esc_sel_next;
            acc_reg     <= acc_next;
            ink_reg     <= ink_next;
            paper_reg   <= paper_next;
        end
    end

    a_esc_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        esc_pos_reg <= ESC_LAST)
        else $error("escape position beyond last digit");

endmodule

// ===== hw/rtl/tccp_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back end.
// Depends on tccp_pkg for the command type and depth.
module tccp_queue
    import tccp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("command popped from empty queue");

endmodule

// ===== hw/rtl/tccp_back.sv =====
`timescale 1ns / 1ps
// Back end: keeps the pixel cursor, applies line wrap and emits glyph draw requests
// through an output register. Depends on tccp_pkg and tccp_out_if.
module tccp_back
    import tccp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    tccp_out_if.source  out_ch
);

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic        out_valid_reg;
    logic [7:0]  glyph_code_reg;
    logic [15:0] draw_x_reg;
    logic [15:0] draw_y_reg;
    logic [31:0] ink_reg;
    logic [31:0] paper_reg;

    logic [7:0]  step_h;
    logic [6:0]  step_w;
    logic [16:0] wrap_sum;
    logic        wrap;
    logic [16:0] y_down_sum;
    logic [15:0] y_down;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [16:0] x_adv_sum;
    logic [15:0] x_adv;
    logic        out_free;
    logic        emit;

    assign step_h     = {cfg.text_scale, 4'b0000};
    assign step_w     = {cfg.text_scale, 3'b000};
    assign wrap_sum   = {1'b0, cursor_x_reg} + {9'd0, step_h};
    assign wrap       = wrap_sum > {1'b0, cfg.screen_width};
    assign y_down_sum = {1'b0, cursor_y_reg} + {9'd0, step_h};
    assign y_down     = y_down_sum[16] ? 16'hFFFF : y_down_sum[15:0];
    assign draw_x     = wrap ? 16'd0 : cursor_x_reg;
    assign draw_y     = wrap ? y_down : cursor_y_reg;
    assign x_adv_sum  = {1'b0, draw_x} + {10'd0, step_w};
    assign x_adv      = x_adv_sum[16] ? 16'hFFFF : x_adv_sum[15:0];

    assign out_free = !out_valid_reg || out_ch.ready;
    // Cursor controls always drain; a glyph waits for room in the output register
    assign pop      = head_valid && (head_cmd.op != CMD_GLYPH || out_free);
    assign emit     = pop && head_cmd.op == CMD_GLYPH;

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (pop)
        begin
            unique case (head_cmd.op)
                CMD_LF:
                begin
                    cursor_y_next = y_down;
                end
                CMD_CR:
                begin
                    cursor_x_next = '0;
                end
                CMD_GLYPH:
                begin
                    cursor_x_next = x_adv;
                    cursor_y_next = draw_y;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= '0;
            cursor_y_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            glyph_code_reg <= head_cmd.code;
            draw_x_reg     <= draw_x;
            draw_y_reg     <= draw_y;
            ink_reg        <= head_cmd.ink;
            paper_reg      <= head_cmd.paper;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.glyph_code  = glyph_code_reg;
    assign out_ch.draw_x      = draw_x_reg;
    assign out_ch.draw_y      = draw_y_reg;
    assign out_ch.ink_color   = ink_reg;
    assign out_ch.paper_color = paper_reg;

    a_y_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_y_reg >= $past(cursor_y_reg))
        else $error("cursor row moved up");

    a_out_from_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("draw request without a glyph command");

endmodule

// ===== hw/rtl/text_console_command_parser.sv =====
`timescale 1ns / 1ps
// Text console command parser, top level: registers, front end, queue, back end.
// Depends on tccp_pkg, tccp_in_if, tccp_out_if and the tccp_* modules.

// Takes one text byte per cycle while the command queue has room, and gives one
// glyph draw request for each printable byte. The front end parses escapes and
// colors and queues a command at the edge that accepts the byte; the back end
// takes it from the head of the queue once the output register has room, updates
// the cursor and loads the output register, from which the request is offered.
// A two-entry command queue lets the input keep flowing for a while when the
// draw request side stalls; line feed, carriage return and escape bytes use a
// queue slot or none but never produce a request. Configuration writes take
// effect on the next cycle and belong only in idle periods.
module text_console_command_parser
    import tccp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    tccp_in_if.sink            in_ch,
    tccp_out_if.source         out_ch
);

    cfg_t      cfg;
    cfg_load_t cfg_load;
    logic      q_full;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    logic      head_valid;
    cmd_t      head_cmd;

    assign pready = 1'b1;

    tccp_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cfg      (cfg),
        .cfg_load (cfg_load)
    );

    tccp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg      (cfg),
        .cfg_load (cfg_load),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tccp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    tccp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule
